/* rtl/core/u8dd_pkg.sv */
package u8dd_pkg;

   localparam int CP_W   = 21;
   localparam int UNIT_W = 16;

   localparam logic [15:0] S_BASE = 16'hAC00;
   localparam logic [15:0] S_END  = 16'hD7A4;
   localparam logic [15:0] L_BASE = 16'h1100;
   localparam logic [15:0] V_BASE = 16'h1161;
   localparam logic [15:0] T_BASE = 16'h11A7;
   localparam logic [8:0]  V_COUNT = 9'd21;
   localparam logic [13:0] T_COUNT = 14'd28;

   // reciprocals for s/28 and s/588, applied to s >> 2
   localparam logic [24:0] Q_RECIP = 25'd4682;
   localparam int          Q_SHIFT = 15;
   localparam logic [23:0] L_RECIP = 24'd3567;
   localparam int          L_SHIFT = 19;

   localparam logic [15:0] MARK_GRAVE   = 16'h0300;
   localparam logic [15:0] MARK_ACUTE   = 16'h0301;
   localparam logic [15:0] MARK_CIRC    = 16'h0302;
   localparam logic [15:0] MARK_TILDE   = 16'h0303;
   localparam logic [15:0] MARK_DIAER   = 16'h0308;
   localparam logic [15:0] MARK_CEDILLA = 16'h0327;

   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;

   typedef struct packed {
      logic       ok;
      logic [1:0] nf;
   } lead_type;

   typedef struct packed {
      logic            cp_v;
      logic [CP_W-1:0] cp;
      logic            ext_v;
      logic [6:0]      ext;
      logic            last;
   } job_type;

   typedef struct packed {
      logic        hit;
      logic [6:0]  base;
      logic [15:0] mark;
   } latin_type;

   function automatic lead_type lead_of(input logic [7:0] b);
      lead_type r;
      r.ok = 1'b1;
      r.nf = 2'd0;
      if (b[7] == 1'b0) begin
         r.nf = 2'd0;
      end else if ((b & LEAD2_MASK) == 8'hC0) begin
         r.nf = 2'd1;
      end else if ((b & LEAD3_MASK) == 8'hE0) begin
         r.nf = 2'd2;
      end else if ((b & LEAD4_MASK) == 8'hF0) begin
         r.nf = 2'd3;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // code points 0xC0..0xFF; bit 5 selects lower case
   function automatic latin_type latin_of(input logic [5:0] low);
      latin_type r;
      r.hit  = 1'b1;
      r.base = 7'h41;
      r.mark = MARK_GRAVE;
      case (low[4:0])
         5'h00: begin r.base = 7'h41; r.mark = MARK_GRAVE;   end
         5'h01: begin r.base = 7'h41; r.mark = MARK_ACUTE;   end
         5'h02: begin r.base = 7'h41; r.mark = MARK_CIRC;    end
         5'h03: begin r.base = 7'h41; r.mark = MARK_TILDE;   end
         5'h04: begin r.base = 7'h41; r.mark = MARK_DIAER;   end
         5'h07: begin r.base = 7'h43; r.mark = MARK_CEDILLA; end
         5'h08: begin r.base = 7'h45; r.mark = MARK_GRAVE;   end
         5'h09: begin r.base = 7'h45; r.mark = MARK_ACUTE;   end
         5'h0A: begin r.base = 7'h45; r.mark = MARK_CIRC;    end
         5'h0B: begin r.base = 7'h45; r.mark = MARK_DIAER;   end
         5'h0C: begin r.base = 7'h49; r.mark = MARK_GRAVE;   end
         5'h0D: begin r.base = 7'h49; r.mark = MARK_ACUTE;   end
         5'h0E: begin r.base = 7'h49; r.mark = MARK_CIRC;    end
         5'h0F: begin r.base = 7'h49; r.mark = MARK_DIAER;   end
         5'h11: begin r.base = 7'h4E; r.mark = MARK_TILDE;   end
         5'h12: begin r.base = 7'h4F; r.mark = MARK_GRAVE;   end
         5'h13: begin r.base = 7'h4F; r.mark = MARK_ACUTE;   end
         5'h14: begin r.base = 7'h4F; r.mark = MARK_CIRC;    end
         5'h15: begin r.base = 7'h4F; r.mark = MARK_TILDE;   end
         5'h16: begin r.base = 7'h4F; r.mark = MARK_DIAER;   end
         5'h19: begin r.base = 7'h55; r.mark = MARK_GRAVE;   end
         5'h1A: begin r.base = 7'h55; r.mark = MARK_ACUTE;   end
         5'h1B: begin r.base = 7'h55; r.mark = MARK_CIRC;    end
         5'h1C: begin r.base = 7'h55; r.mark = MARK_DIAER;   end
         default: r.hit = 1'b0;
      endcase
      if (low[5]) begin
         r.base = r.base | 7'h20;
      end
      return r;
   endfunction

endpackage

/* rtl/core/u8dd_decode.sv */
module u8dd_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             job_valid,
   output u8dd_pkg::job_type job,
   input  logic             job_free
);
   import u8dd_pkg::*;

   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [1:0] need_ff, need_in;
   job_type    job_ff, job_in;
   logic       job_v_ff, job_v_in;
   lead_type   lead_b;
   logic       accept;
   logic [7:0] r0, r1;

   assign req_tready = !job_v_ff || job_free;
   assign accept     = req_tvalid && req_tready;
   assign job_valid  = job_v_ff;
   assign job        = job_ff;

   always_comb begin
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      need_in     = need_ff;
      job_in      = '0;
      job_in.last = req_tlast;
      lead_b      = lead_of(req_tdata);
      case (need_ff)
         2'd0: begin
            if (lead_b.ok && lead_b.nf == 2'd0) begin
               job_in.cp_v = 1'b1;
               job_in.cp   = {13'b0, req_tdata};
            end else if (lead_b.ok) begin
               held_in[0]  = req_tdata;
               held_cnt_in = 2'd1;
               need_in     = lead_b.nf;
            end
         end
         2'd1: begin
            job_in.cp_v = 1'b1;
            case (held_cnt_ff)
               2'd1: job_in.cp = {10'b0, held_ff[0][4:0], req_tdata[5:0]};
               2'd2: job_in.cp = {5'b0, held_ff[0][3:0], held_ff[1][5:0], req_tdata[5:0]};
               2'd3: job_in.cp = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0],
                                  req_tdata[5:0]};
               default: job_in.cp = {14'b0, req_tdata[6:0]};
            endcase
            held_cnt_in = 2'd0;
            need_in     = 2'd0;
         end
         default: begin
            case (held_cnt_ff)
               2'd0: held_in[0] = req_tdata;
               2'd1: held_in[1] = req_tdata;
               2'd2: held_in[2] = req_tdata;
               default: ;
            endcase
            if (held_cnt_ff != 2'd3) begin
               held_cnt_in = held_cnt_ff + 2'd1;
            end
            need_in = need_ff - 2'd1;
         end
      endcase
      // unfinished sequence at end: followers rescanned as fresh starts
      r0 = held_in[1];
      r1 = held_in[2];
      if (req_tlast) begin
         if (need_in != 2'd0) begin
            case (held_cnt_in)
               2'd2: begin
                  if (!r0[7]) begin
                     job_in.cp_v = 1'b1;
                     job_in.cp   = {13'b0, r0};
                  end
               end
               2'd3: begin
                  if (!r0[7]) begin
                     job_in.cp_v = 1'b1;
                     job_in.cp   = {13'b0, r0};
                     if (!r1[7]) begin
                        job_in.ext_v = 1'b1;
                        job_in.ext   = r1[6:0];
                     end
                  end else if ((r0 & LEAD2_MASK) == 8'hC0) begin
                     job_in.cp_v = 1'b1;
                     job_in.cp   = {10'b0, r0[4:0], r1[5:0]};
                  end else if (!r1[7]) begin
                     job_in.cp_v = 1'b1;
                     job_in.cp   = {13'b0, r1};
                  end
               end
               default: ;
            endcase
         end
         held_cnt_in = 2'd0;
         need_in     = 2'd0;
      end
      if (accept) begin
         job_v_in = job_in.cp_v || req_tlast;
      end else if (job_free) begin
         job_v_in = 1'b0;
      end else begin
         job_v_in = job_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         need_ff     <= 2'd0;
         job_v_ff    <= 1'b0;
      end else begin
         job_v_ff <= job_v_in;
         if (accept) begin
            held_cnt_ff <= held_cnt_in;
            need_ff     <= need_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
         job_ff  <= job_in;
      end
   end

endmodule

/* rtl/core/u8dd_expand.sv */
module u8dd_expand (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  u8dd_pkg::job_type job,
   output logic              job_free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);
   import u8dd_pkg::*;

   logic [13:0] s;
   logic [11:0] x;
   logic [24:0] q_prod;
   logic [23:0] l_prod;
   logic [8:0]  q;
   logic [4:0]  l;
   logic [8:0]  v_full;
   logic [13:0] t_full;
   logic [4:0]  v, t;
   logic        hangul, latin_hit;
   latin_type   latin;

   logic [UNIT_W-1:0] unit_in [3];
   logic [UNIT_W-1:0] unit_ff [3];
   logic [1:0]        cnt_in, cnt_ff;
   logic [1:0]        idx_ff;
   logic              hv_in, hv_ff;
   logic              last_ff;
   logic              grp_v_ff;
   logic              pop, final_pop, take;

   always_comb begin
      s      = 14'(job.cp[15:0] - S_BASE);
      x      = s[13:2];
      q_prod = {13'b0, x} * Q_RECIP;
      l_prod = {12'b0, x} * L_RECIP;
      q      = q_prod[Q_SHIFT+8:Q_SHIFT];
      l      = l_prod[L_SHIFT+4:L_SHIFT];
      v_full = q - ({4'b0, l} * V_COUNT);
      t_full = s - ({5'b0, q} * T_COUNT);
      v      = v_full[4:0];
      t      = t_full[4:0];
      hangul = (job.cp >= {5'b0, S_BASE}) && (job.cp < {5'b0, S_END});
      latin  = latin_of(job.cp[5:0]);
      latin_hit = (job.cp[CP_W-1:6] == 15'd3) && latin.hit;

      unit_in[0] = job.cp[15:0];
      unit_in[1] = {9'b0, job.ext};
      unit_in[2] = T_BASE + {11'b0, t};
      cnt_in     = 2'd1;
      hv_in      = 1'b1;
      if (!job.cp_v) begin
         unit_in[0] = '0;
         hv_in      = 1'b0;
      end else if (hangul) begin
         unit_in[0] = L_BASE + {11'b0, l};
         unit_in[1] = V_BASE + {11'b0, v};
         cnt_in     = (t != 5'd0) ? 2'd3 : 2'd2;
      end else if (latin_hit) begin
         unit_in[0] = {9'b0, latin.base};
         unit_in[1] = latin.mark;
         cnt_in     = 2'd2;
      end else if (job.ext_v) begin
         cnt_in = 2'd2;
      end
   end

   assign pop       = grp_v_ff && rsp_tready;
   assign final_pop = pop && (idx_ff == cnt_ff - 2'd1);
   assign job_free  = !grp_v_ff || final_pop;
   assign take      = job_valid && job_free;

   assign rsp_tvalid = grp_v_ff;
   assign rsp_tuser  = hv_ff;
   assign rsp_tlast  = last_ff && (idx_ff == cnt_ff - 2'd1);

   always_comb begin
      case (idx_ff)
         2'd0: rsp_tdata = unit_ff[0];
         2'd1: rsp_tdata = unit_ff[1];
         2'd2: rsp_tdata = unit_ff[2];
         default: rsp_tdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_v_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (take) begin
         grp_v_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (final_pop) begin
         grp_v_ff <= 1'b0;
      end else if (pop) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         unit_ff <= unit_in;
         cnt_ff  <= cnt_in;
         hv_ff   <= hv_in;
         last_ff <= job.last;
      end
   end

endmodule

/* rtl/core/utf8_decode_decompose_top.sv */
// utf-8 byte stream in, decomposed 16-bit code units out
// req channel: one text byte per word in req_tdata, req_tlast marks the
//   final byte of a text
// rsp channel: one code unit per word; rsp_tuser is 0 only on the bare end
//   word sent when a text ends with nothing to show; rsp_tlast marks the
//   final word caused by an end-of-text byte
// a hangul syllable gives 2 or 3 jamo words, one of 48 accented latin
//   letters gives a base letter word and a combining mark word, any other
//   code point gives its low 16 bits; stray bytes give nothing
// each decoded byte passes through the job register and then the output register
// throughput: one byte per cycle while rsp_tready is high and each byte gives at most one word;
//   a byte that gives n words holds the output register until all n are sent,
//   with one decoded byte waiting in the job register behind it
// when rsp_tready is low, the output word holds and req_tready drops once
//   the job register is also full
// reset clears the open sequence and drops any words in flight
module utf8_decode_decompose_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // code_unit
   output logic        rsp_tuser,   // has_value
   output logic        rsp_tlast
);
   import u8dd_pkg::*;

   job_type job;
   logic    job_valid;
   logic    job_free;

   u8dd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .job_valid  (job_valid),
      .job        (job),
      .job_free   (job_free)
   );

   u8dd_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_free   (job_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
